/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define PDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check a property at every clock edge, reset included.
`define PDC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

/* rtl/core/pdc_pkg.sv */
package pdc_pkg;

    // Width of the saturating error accumulator
    localparam int SUM_WIDTH = 40;

    localparam int IN_W    = 16;
    localparam int GAIN_W  = 32;
    localparam int ERR_W   = IN_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int DUTY_W  = 17;
    localparam int KE_W    = GAIN_W + ERR_W;
    localparam int KD_W    = GAIN_W + DIFF_W;
    localparam int PROD_W  = GAIN_W + SUM_WIDTH;
    localparam int TERM_W  = 62;
    localparam int CMP_W   = (PROD_W > TERM_W) ? PROD_W : TERM_W;
    localparam int TOT_W   = TERM_W + 1;

    // Chunked rebuild of the integral product
    localparam int CHUNK_W = 16;
    localparam int NCHUNK  = (SUM_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int EXT_W   = NCHUNK * CHUNK_W;
    localparam int CNT_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int CPROD_W = GAIN_W + CHUNK_W + 1;

    // Division by 25600: drop 8 bits, then multiply by a reciprocal of 100
    localparam int SCALE_SHIFT = 8;
    localparam int QX_W        = 23;
    localparam int MULT_W      = 24;
    localparam int QP_W        = QX_W + MULT_W;
    localparam int DIV_SHIFT   = 30;
    localparam logic [MULT_W-1:0] DIV_MULT = 24'd10737419;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    localparam logic signed [CMP_W-1:0] TERM_LIMIT = CMP_W'(1) << 60;
    localparam logic signed [TOT_W-1:0] TOTAL_LOW  = TOT_W'(25600);
    localparam logic signed [TOT_W-1:0] TOTAL_FULL = TOT_W'(64'd1677721600);
    localparam logic [DUTY_W-1:0]       DUTY_FULL  = 17'd65536;

    localparam logic signed [ERR_W-1:0] BAND_HI = 17'sd256;
    localparam logic signed [ERR_W-1:0] BAND_LO = -17'sd256;

    // Configuration register indexes
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_PROP  = 2'd0;
    localparam cfg_idx_t CFG_INTEG = 2'd1;
    localparam cfg_idx_t CFG_DERIV = 2'd2;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop;
        logic signed [GAIN_W-1:0] integ;
        logic signed [GAIN_W-1:0] deriv;
    } gains_t;

    localparam gains_t GAINS_RESET = '{
        prop:  32'sd786432,
        integ: 32'sd655,
        deriv: 32'sd6554
    };

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
        logic                     band;
    } err_item_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [KE_W-1:0]  kp_e;
        logic signed [KD_W-1:0]  kd_d;
        logic signed [KE_W-1:0]  ki_e;
        logic                    band;
    } prod_item_t;

    typedef struct packed {
        logic signed [TOT_W-1:0] total;
        logic                    band;
    } tot_item_t;

    typedef enum logic {
        RC_IDLE,
        RC_RUN
    } rc_state_t;

endpackage

/* rtl/core/pdc_front.sv */
module pdc_front import pdc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [IN_W-1:0]  meas,
    input  logic signed [IN_W-1:0]  targ,
    output logic                    out_valid,
    input  logic                    out_ready,
    output err_item_t               out_item
);

    logic                    v1_reg;
    logic                    v2_reg;
    logic signed [IN_W-1:0]  meas_reg;
    logic signed [IN_W-1:0]  targ_reg;
    logic signed [ERR_W-1:0] last_err_reg;
    err_item_t               item_reg;
    err_item_t               item_next;
    logic signed [ERR_W-1:0] err;
    logic                    ready2;

    assign ready2   = !v2_reg || out_ready;
    assign in_ready = !v1_reg || ready2;

    // Form error, derivative and band flag
    always_comb begin
        err            = ERR_W'(targ_reg) - ERR_W'(meas_reg);
        item_next.err  = err;
        item_next.diff = DIFF_W'(err) - DIFF_W'(last_err_reg);
        item_next.band = (err >= BAND_LO) && (err <= BAND_HI);
    end

    // Advance valid bits and the previous error
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            last_err_reg <= '0;
        end else begin
            if (in_ready) begin
                v1_reg <= in_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (v1_reg && ready2) begin
                last_err_reg <= err;
            end
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            meas_reg <= meas;
            targ_reg <= targ;
        end
        if (v1_reg && ready2) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;

endmodule

/* rtl/core/pdc_mult.sv */
module pdc_mult import pdc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  gains_t     gains,
    input  logic       in_valid,
    output logic       in_ready,
    input  err_item_t  in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output prod_item_t out_item
);

    logic       v_reg;
    prod_item_t item_reg;
    prod_item_t item_next;

    assign in_ready = !v_reg || out_ready;

    // Scale error and derivative by the gains
    always_comb begin
        item_next.err  = in_item.err;
        item_next.kp_e = KE_W'(gains.prop) * KE_W'(in_item.err);
        item_next.kd_d = KD_W'(gains.deriv) * KD_W'(in_item.diff);
        item_next.ki_e = KE_W'(gains.integ) * KE_W'(in_item.err);
        item_next.band = in_item.band;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = v_reg;
    assign out_item  = item_reg;

endmodule

/* rtl/core/pdc_integ.sv */
module pdc_integ import pdc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic signed [GAIN_W-1:0] ki,
    input  logic                     ki_load,
    output logic                     busy,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  prod_item_t               in_item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output tot_item_t                out_item
);

    logic signed [SUM_WIDTH-1:0] sum_reg;
    logic signed [PROD_W-1:0]    kisum_reg;
    logic                        open_reg;
    logic                        v_reg;
    tot_item_t                   item_reg;
    rc_state_t                   rc_state_reg;
    rc_state_t                   rc_state_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_next;

    logic                        take;
    logic signed [SUM_WIDTH:0]   sum_add;
    logic                        over;
    logic                        under;
    logic signed [SUM_WIDTH-1:0] sum_sel;
    logic signed [PROD_W-1:0]    ki_wide;
    logic signed [PROD_W-1:0]    ki_max;
    logic signed [PROD_W-1:0]    ki_min;
    logic signed [PROD_W-1:0]    kisum_add;
    logic signed [PROD_W-1:0]    kisum_sel;
    logic signed [PROD_W-1:0]    kisum_next;
    logic signed [CMP_W-1:0]     kisum_cmp;
    logic signed [CMP_W-1:0]     term_cmp;
    logic signed [TERM_W-1:0]    term;
    logic signed [TOT_W-1:0]     total;
    logic                        open_next;
    logic signed [EXT_W-1:0]     sum_ext;
    logic [CHUNK_W-1:0]          chunk;
    logic signed [CHUNK_W:0]     chunk_op;
    logic signed [CPROD_W-1:0]   chunk_prod;

    assign take     = in_valid && in_ready;
    assign in_ready = !v_reg || out_ready;

    // While open_reg is set, update the error sum with saturation, tracking Ki times the sum alongside
    always_comb begin
        sum_add   = (SUM_WIDTH+1)'(sum_reg) + (SUM_WIDTH+1)'(in_item.err);
        over      = sum_add > (SUM_WIDTH+1)'(SUM_MAX);
        under     = sum_add < (SUM_WIDTH+1)'(SUM_MIN);
        ki_wide   = PROD_W'(ki);
        ki_max    = (ki_wide <<< (SUM_WIDTH-1)) - ki_wide;
        ki_min    = -(ki_wide <<< (SUM_WIDTH-1));
        kisum_add = kisum_reg + PROD_W'(in_item.ki_e);
        sum_sel   = sum_reg;
        kisum_sel = kisum_reg;
        if (open_reg) begin
            if (over) begin
                sum_sel   = SUM_MAX;
                kisum_sel = ki_max;
            end else if (under) begin
                sum_sel   = SUM_MIN;
                kisum_sel = ki_min;
            end else begin
                sum_sel   = sum_add[SUM_WIDTH-1:0];
                kisum_sel = kisum_add;
            end
        end
    end

    // Clamp the integral term, add the other terms, find the unclamped band
    always_comb begin
        kisum_cmp = CMP_W'(kisum_sel);
        if (kisum_cmp > TERM_LIMIT) begin
            term_cmp = TERM_LIMIT;
        end else if (kisum_cmp < -TERM_LIMIT) begin
            term_cmp = -TERM_LIMIT;
        end else begin
            term_cmp = kisum_cmp;
        end
        term      = term_cmp[TERM_W-1:0];
        total     = TOT_W'(term) + TOT_W'(in_item.kp_e) + TOT_W'(in_item.kd_d);
        open_next = (total >= TOTAL_LOW) && (total < TOTAL_FULL);
    end

    // One chunk of the sum per rebuild step, top chunk first
    always_comb begin
        sum_ext    = EXT_W'(sum_reg);
        chunk      = sum_ext[cnt_reg*CHUNK_W +: CHUNK_W];
        chunk_op   = (cnt_reg == CNT_W'(NCHUNK-1)) ? {chunk[CHUNK_W-1], chunk}
                                                   : {1'b0, chunk};
        chunk_prod = CPROD_W'(ki) * CPROD_W'(chunk_op);
    end

    // Rebuild sequencer: next state
    always_comb begin
        rc_state_next = rc_state_reg;
        cnt_next      = cnt_reg;
        if (ki_load) begin
            rc_state_next = RC_RUN;
            cnt_next      = CNT_W'(NCHUNK-1);
        end else begin
            unique case (rc_state_reg)
                RC_IDLE: begin
                end
                RC_RUN: begin
                    if (cnt_reg == '0) begin
                        rc_state_next = RC_IDLE;
                    end else begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                default: begin
                    rc_state_next = RC_IDLE;
                end
            endcase
        end
    end

    // Rebuild sequencer: outputs
    always_comb begin
        busy       = 1'b0;
        kisum_next = kisum_reg;
        if (ki_load) begin
            kisum_next = '0;
        end else begin
            unique case (rc_state_reg)
                RC_IDLE: begin
                    if (take) begin
                        kisum_next = kisum_sel;
                    end
                end
                RC_RUN: begin
                    busy       = 1'b1;
                    kisum_next = (kisum_reg <<< CHUNK_W) + PROD_W'(chunk_prod);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg      <= '0;
            kisum_reg    <= '0;
            open_reg     <= 1'b0;
            v_reg        <= 1'b0;
            rc_state_reg <= RC_IDLE;
            cnt_reg      <= '0;
        end else begin
            rc_state_reg <= rc_state_next;
            cnt_reg      <= cnt_next;
            kisum_reg    <= kisum_next;
            if (in_ready) begin
                v_reg <= in_valid;
            end
            if (take) begin
                sum_reg  <= sum_sel;
                open_reg <= open_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.total <= total;
            item_reg.band  <= in_item.band;
        end
    end

    assign out_valid = v_reg;
    assign out_item  = item_reg;

endmodule

/* rtl/core/pdc_out.sv */
module pdc_out import pdc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  tot_item_t         in_item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DUTY_W-1:0] m_duty,
    output logic              m_in_band
);

    logic              m_valid_reg;
    logic [DUTY_W-1:0] m_duty_reg;
    logic              m_in_band_reg;
    logic [DUTY_W-1:0] duty_next;
    logic [QX_W-1:0]   scaled;
    logic [QP_W-1:0]   quot_prod;

    assign in_ready = !m_valid_reg || m_ready;

    // Divide by 25600 and clamp to 0..full
    always_comb begin
        scaled    = in_item.total[SCALE_SHIFT +: QX_W];
        quot_prod = QP_W'(scaled) * QP_W'(DIV_MULT);
        if (in_item.total[TOT_W-1] || (in_item.total == '0)) begin
            duty_next = '0;
        end else if (in_item.total >= TOTAL_FULL) begin
            duty_next = DUTY_FULL;
        end else begin
            duty_next = quot_prod[DIV_SHIFT +: DUTY_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_ready) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            m_duty_reg    <= duty_next;
            m_in_band_reg <= in_item.band;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_duty    = m_duty_reg;
    assign m_in_band = m_in_band_reg;

endmodule

/* rtl/core/pid_duty_controller.sv */
// Throughput: one item per cycle through a five-register pipeline while m_ready is
// high and no integ_gain rebuild holds off input. A write to integ_gain holds off
// input in its own cycle and while the integral product is rebuilt, one 16-bit
// chunk of the error sum a cycle.
// Reset (aresetn low, synchronous) clears sum, history and pipeline and
// restores the default gains.
module pid_duty_controller import pdc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [IN_W-1:0]  s_measured_temp,
    input  logic signed [IN_W-1:0]  s_target_temp,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [DUTY_W-1:0]       m_duty,
    output logic                    m_in_band,
    input  logic                    cfg_wr_en,
    input  cfg_idx_t                cfg_wr_index,
    input  logic [GAIN_W-1:0]       cfg_wr_data
);

    gains_t     gains_reg;
    gains_t     gains_next;
    logic       ki_load;
    logic       busy;
    logic       hold_in;
    logic       front_ready;
    logic       err_valid;
    logic       err_ready;
    err_item_t  err_item;
    logic       prod_valid;
    logic       prod_ready;
    prod_item_t prod_item;
    logic       tot_valid;
    logic       tot_ready;
    tot_item_t  tot_item;

    // Decode configuration writes
    always_comb begin
        gains_next = gains_reg;
        ki_load    = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_PROP:  gains_next.prop = cfg_wr_data;
                CFG_INTEG: begin
                    gains_next.integ = cfg_wr_data;
                    ki_load          = 1'b1;
                end
                CFG_DERIV: gains_next.deriv = cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg <= GAINS_RESET;
        end else begin
            gains_reg <= gains_next;
        end
    end

    // Hold off input during an integ_gain write and while the product is rebuilt
    assign hold_in = busy || ki_load;
    assign s_ready = front_ready && !hold_in;

    pdc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid && !hold_in),
        .in_ready  (front_ready),
        .meas      (s_measured_temp),
        .targ      (s_target_temp),
        .out_valid (err_valid),
        .out_ready (err_ready),
        .out_item  (err_item)
    );

    pdc_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gains     (gains_reg),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_item   (err_item),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_item  (prod_item)
    );

    pdc_integ u_integ (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ki        (gains_reg.integ),
        .ki_load   (ki_load),
        .busy      (busy),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_item   (prod_item),
        .out_valid (tot_valid),
        .out_ready (tot_ready),
        .out_item  (tot_item)
    );

    pdc_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (tot_valid),
        .in_ready  (tot_ready),
        .in_item   (tot_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_duty    (m_duty),
        .m_in_band (m_in_band)
    );

endmodule

/* rtl/core/pdc_checker.sv */
`include "assert_macros.svh"

module pdc_checker import pdc_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DUTY_W-1:0] m_duty,
    input logic              m_in_band,
    input logic              cfg_wr_en,
    input cfg_idx_t          cfg_wr_index
);

    logic [DUTY_W+1:0] out_word;
    logic              integ_wr;

    assign out_word = {m_valid, m_duty, m_in_band};
    assign integ_wr = cfg_wr_en && (cfg_wr_index == CFG_INTEG);

    // Duty never exceeds full on
    `PDC_ASSERT(a_duty_range, m_valid |-> (m_duty <= DUTY_FULL), "duty above full scale")

    // Reset empties the output register
    `PDC_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

    // A stalled result holds
    `PDC_ASSERT(a_out_hold, m_valid && !m_ready |=> $stable(out_word), "stalled result changed")

    // Input is held off while the integral product is rebuilt
    `PDC_ASSERT(a_rebuild_block, integ_wr |=> !s_ready, "item taken during integral rebuild")

endmodule

bind pid_duty_controller pdc_checker u_pdc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_duty       (m_duty),
    .m_in_band    (m_in_band),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_index (cfg_wr_index)
);
